FILE: sv/wahr_pkg.sv
// ----------------------------------------------------------------------------
// wahr_pkg
// shared widths, constants and operand types of the wah resonator filter
// ----------------------------------------------------------------------------
package wahr_pkg;

  localparam int FS_W      = 32;   // freq_scale, unsigned q0.32
  localparam int FREQ_W    = 16;   // centre frequency in hz
  localparam int Q_W       = 24;   // q, unsigned q8.16
  localparam int TH_W      = 32;   // theta, q2.30, at most 2.0
  localparam int R_W       = 31;   // pole radius, q1.30, at most 1.0
  localparam int MA_W      = 34;   // multiplier operand a
  localparam int MB_W      = 33;   // multiplier operand b
  localparam int PROD_W    = MA_W + MB_W;
  localparam int DIV_STEPS = 30;   // quotient bits below 1.0 in q2.30
  localparam int DIV_CNT_W = 5;

  localparam logic [FS_W-1:0] FS_RESET = 32'd562214;
  localparam logic [R_W-1:0]  ONE_Q30  = 31'h4000_0000;

  typedef logic signed [MA_W-1:0]   mul_a_t;
  typedef logic signed [MB_W-1:0]   mul_b_t;
  typedef logic signed [PROD_W-1:0] prod_t;

endpackage

FILE: sv/wahr_if.sv
// ----------------------------------------------------------------------------
// wahr channel interfaces
// valid/ready channels for samples in, samples out and the config write
// ----------------------------------------------------------------------------
interface wahr_in_if #(
  parameter int SAMPLE_BITS = 24
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_in;
  logic [15:0]                   centre_freq;
  logic [23:0]                   q_value;
  logic                          block_start;

  modport source (output valid, sample_in, centre_freq, q_value, block_start, input ready);
  modport sink   (input valid, sample_in, centre_freq, q_value, block_start, output ready);
endinterface

interface wahr_out_if #(
  parameter int SAMPLE_BITS = 24
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;

  modport source (output valid, sample_out, input ready);
  modport sink   (input valid, sample_out, output ready);
endinterface

interface wahr_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

FILE: sv/wah_resonator_filter.sv
// ----------------------------------------------------------------------------
// wah_resonator_filter
// two-pole resonant filter, one shared multiplier under a step sequencer
// ----------------------------------------------------------------------------
//   channel  dir  payload                                         beat when
//   din      in   sample_in, centre_freq, q_value, block_start     valid & ready
//   dout     out  sample_out                                      valid & ready
//   cfg      in   data (freq_scale)                               valid & ready
//
// a plain sample makes six passes through the shared multiplier
// a block start adds six more multiplies and a wait in ST_DIV until the divider is done
// din is ready only while the sequencer is idle; cfg is always ready
// a finished sample sits in the output register while the next beat is taken
// sync reset clears coefficients and filter history, freq_scale goes to 562214
// ----------------------------------------------------------------------------
module wah_resonator_filter
  import wahr_pkg::*;
#(
  parameter int SAMPLE_BITS = 24
) (
  input  logic                   clk,
  input  logic                   rst,
  wahr_in_if.sink                din,
  wahr_out_if.source             dout,
  wahr_cfg_if.sink               cfg
);

  localparam int W_W    = 40;
  localparam int WS_W   = 47;
  localparam int ACC_W  = 75;
  localparam int M_W    = ACC_W - 30;
  localparam int WL_W   = 20;
  localparam int ST_W   = 5;

  localparam logic signed [WS_W-1:0] W_HI = WS_W'((64'sd1 <<< (W_W - 1)) - 64'sd1);
  localparam logic signed [WS_W-1:0] W_LO = WS_W'(-(64'sd1 <<< (W_W - 1)));
  localparam logic signed [M_W-1:0]  Y_HI = M_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [M_W-1:0]  Y_LO = M_W'(-(64'sd1 <<< (SAMPLE_BITS - 1)));

  localparam logic [ST_W-1:0] ST_IDLE  = 5'd0;
  localparam logic [ST_W-1:0] ST_TH_I  = 5'd1;
  localparam logic [ST_W-1:0] ST_TH_T  = 5'd2;
  localparam logic [ST_W-1:0] ST_COS_I = 5'd3;
  localparam logic [ST_W-1:0] ST_COS_T = 5'd4;
  localparam logic [ST_W-1:0] ST_DIV   = 5'd5;
  localparam logic [ST_W-1:0] ST_B1_I  = 5'd6;
  localparam logic [ST_W-1:0] ST_B1_T  = 5'd7;
  localparam logic [ST_W-1:0] ST_B2_I  = 5'd8;
  localparam logic [ST_W-1:0] ST_B2_T  = 5'd9;
  localparam logic [ST_W-1:0] ST_G_I   = 5'd10;
  localparam logic [ST_W-1:0] ST_G_T   = 5'd11;
  localparam logic [ST_W-1:0] ST_C_I   = 5'd12;
  localparam logic [ST_W-1:0] ST_C_T   = 5'd13;
  localparam logic [ST_W-1:0] ST_M1H   = 5'd14;
  localparam logic [ST_W-1:0] ST_M1L   = 5'd15;
  localparam logic [ST_W-1:0] ST_M1S   = 5'd16;
  localparam logic [ST_W-1:0] ST_M2L   = 5'd17;
  localparam logic [ST_W-1:0] ST_M2S   = 5'd18;
  localparam logic [ST_W-1:0] ST_YH    = 5'd19;
  localparam logic [ST_W-1:0] ST_YL    = 5'd20;
  localparam logic [ST_W-1:0] ST_YS    = 5'd21;

  logic [ST_W-1:0]               st;
  logic [FS_W-1:0]               freq_scale;

  // latched item
  logic signed [SAMPLE_BITS-1:0] x;
  logic [FREQ_W-1:0]             freq;
  logic [Q_W-1:0]                qv;

  // coefficient work registers
  logic [TH_W-1:0]               th;
  logic signed [TH_W-1:0]        cosv;
  logic [R_W-1:0]                r;
  logic [TH_W-1:0]               g;

  // filter state
  logic signed [MA_W-1:0]        b1;
  logic [R_W-1:0]                b2;
  logic [TH_W-1:0]               c;
  logic signed [W_W-1:0]         w1;
  logic signed [W_W-1:0]         w2;
  logic signed [WS_W-1:0]        wsum;
  logic signed [ACC_W-1:0]       acc;

  logic                          out_valid;
  logic signed [SAMPLE_BITS-1:0] out_data;

  mul_a_t                        ma;
  mul_b_t                        mb;
  prod_t                         p;
  logic                          div_start;
  logic                          div_done;
  logic [R_W-1:0]                div_r;

  logic [R_W-1:0]                omr;
  logic [R_W-1:0]                sinv;
  logic [45:0]                   th_raw;
  logic [TH_W-1:0]               th_next;
  logic signed [TH_W+1:0]        cos_full;
  logic signed [37:0]            b1_full;
  logic signed [ACC_W-1:0]       p_ext;
  logic signed [ACC_W-1:0]       sum;
  logic signed [M_W-1:0]         m_cur;
  logic signed [WS_W-1:0]        m_ext;
  logic signed [WS_W-1:0]        xs;
  logic signed [WS_W-1:0]        wfull;
  logic signed [W_W-1:0]         w_sat;
  logic signed [SAMPLE_BITS-1:0] y_sat;
  logic                          out_free;

  assign din.ready  = (st == ST_IDLE);
  assign cfg.ready  = 1'b1;
  assign dout.valid = out_valid;
  assign dout.sample_out = out_data;
  assign out_free   = !out_valid || dout.ready;
  assign div_start  = (st == ST_COS_T);

  wahr_mul u_mul (
    .clk (clk),
    .a   (ma),
    .b   (mb),
    .p   (p)
  );

  wahr_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .th    (th),
    .q     (qv),
    .done  (div_done),
    .r     (div_r)
  );

  always_comb begin
    omr      = ONE_Q30 - r;
    sinv     = (th > {1'b0, ONE_Q30}) ? ONE_Q30 : th[R_W-1:0];
    th_raw   = p[47:2];
    th_next  = (th_raw > 46'h8000_0000) ? 32'h8000_0000 : th_raw[TH_W-1:0];
    cos_full = $signed({3'b0, ONE_Q30}) - $signed({2'b0, p[62:31]});
    b1_full  = -$signed(p[66:29]);
    p_ext    = {{(ACC_W-PROD_W){p[PROD_W-1]}}, p};
    sum      = acc + p_ext;
    m_cur    = sum[ACC_W-1:30];
    m_ext    = {{(WS_W-M_W){m_cur[M_W-1]}}, m_cur};
    xs       = {{(WS_W-SAMPLE_BITS){x[SAMPLE_BITS-1]}}, x};
    wfull    = wsum - m_ext;
    if (wfull > W_HI) begin
      w_sat = W_HI[W_W-1:0];
    end else if (wfull < W_LO) begin
      w_sat = W_LO[W_W-1:0];
    end else begin
      w_sat = wfull[W_W-1:0];
    end
    if (m_cur > Y_HI) begin
      y_sat = Y_HI[SAMPLE_BITS-1:0];
    end else if (m_cur < Y_LO) begin
      y_sat = Y_LO[SAMPLE_BITS-1:0];
    end else begin
      y_sat = m_cur[SAMPLE_BITS-1:0];
    end
  end

  // operand select for the shared multiplier; w is split into a signed high
  // part and an unsigned 20-bit low part
  always_comb begin
    ma = '0;
    mb = '0;
    case (st)
      ST_TH_I: begin
        ma = {2'b0, freq_scale};
        mb = {{(MB_W-FREQ_W){1'b0}}, freq};
      end
      ST_COS_I: begin
        ma = {2'b0, th};
        mb = {1'b0, th};
      end
      ST_B1_I: begin
        ma = {{(MA_W-R_W){1'b0}}, r};
        mb = {cosv[TH_W-1], cosv};
      end
      ST_B2_I: begin
        ma = {{(MA_W-R_W){1'b0}}, r};
        mb = {{(MB_W-R_W){1'b0}}, r};
      end
      ST_G_I: begin
        ma = {{(MA_W-R_W){1'b0}}, r};
        mb = {{(MB_W-R_W){1'b0}}, sinv};
      end
      ST_C_I: begin
        ma = {{(MA_W-R_W){1'b0}}, omr};
        mb = {1'b0, g};
      end
      ST_M1H: begin
        ma = b1;
        mb = {{(MB_W-W_W+WL_W){w1[W_W-1]}}, w1[W_W-1:WL_W]};
      end
      ST_M1L: begin
        ma = b1;
        mb = {{(MB_W-WL_W){1'b0}}, w1[WL_W-1:0]};
      end
      ST_M1S: begin
        ma = {{(MA_W-R_W){1'b0}}, b2};
        mb = {{(MB_W-W_W+WL_W){w2[W_W-1]}}, w2[W_W-1:WL_W]};
      end
      ST_M2L: begin
        ma = {{(MA_W-R_W){1'b0}}, b2};
        mb = {{(MB_W-WL_W){1'b0}}, w2[WL_W-1:0]};
      end
      ST_YH: begin
        ma = {2'b0, c};
        mb = {{(MB_W-W_W+WL_W){w1[W_W-1]}}, w1[W_W-1:WL_W]};
      end
      // the low product must stay in place while the output waits
      ST_YL, ST_YS: begin
        ma = {2'b0, c};
        mb = {{(MB_W-WL_W){1'b0}}, w1[WL_W-1:0]};
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st         <= ST_IDLE;
      freq_scale <= FS_RESET;
      b1         <= '0;
      b2         <= '0;
      c          <= '0;
      w1         <= '0;
      w2         <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        freq_scale <= cfg.data;
      end
      // a sample leaving ST_YS refills the output register on the same edge
      if (dout.valid && dout.ready && st != ST_YS) begin
        out_valid <= 1'b0;
      end
      case (st)
        ST_IDLE: begin
          if (din.valid) begin
            x    <= din.sample_in;
            freq <= din.centre_freq;
            qv   <= din.q_value;
            st   <= din.block_start ? ST_TH_I : ST_M1H;
          end
        end
        ST_TH_I:  st <= ST_TH_T;
        ST_TH_T: begin
          th <= th_next;
          st <= ST_COS_I;
        end
        ST_COS_I: st <= ST_COS_T;
        ST_COS_T: begin
          cosv <= cos_full[TH_W-1:0];
          st   <= ST_DIV;
        end
        ST_DIV: begin
          if (div_done) begin
            r  <= div_r;
            st <= ST_B1_I;
          end
        end
        ST_B1_I:  st <= ST_B1_T;
        ST_B1_T: begin
          b1 <= b1_full[MA_W-1:0];
          st <= ST_B2_I;
        end
        ST_B2_I:  st <= ST_B2_T;
        ST_B2_T: begin
          b2 <= p[60:30];
          st <= ST_G_I;
        end
        ST_G_I:   st <= ST_G_T;
        ST_G_T: begin
          g  <= {1'b0, omr} + {1'b0, p[60:30]};
          st <= ST_C_I;
        end
        ST_C_I:   st <= ST_C_T;
        ST_C_T: begin
          c  <= p[61:30];
          st <= ST_M1H;
        end
        ST_M1H:   st <= ST_M1L;
        ST_M1L: begin
          acc <= p_ext <<< WL_W;
          st  <= ST_M1S;
        end
        ST_M1S: begin
          wsum <= xs - m_ext;
          st   <= ST_M2L;
        end
        ST_M2L: begin
          acc <= p_ext <<< WL_W;
          st  <= ST_M2S;
        end
        ST_M2S: begin
          w2 <= w1;
          w1 <= w_sat;
          st <= ST_YH;
        end
        ST_YH:    st <= ST_YL;
        ST_YL: begin
          acc <= p_ext <<< WL_W;
          st  <= ST_YS;
        end
        ST_YS: begin
          // hold here until the output register has room
          if (out_free) begin
            out_data  <= y_sat;
            out_valid <= 1'b1;
            st        <= ST_IDLE;
          end
        end
        default:  st <= ST_IDLE;
      endcase
    end
  end

endmodule

FILE: sv/wahr_mul.sv
// ----------------------------------------------------------------------------
// wahr_mul
// shared signed multiplier with a registered product
// ----------------------------------------------------------------------------
module wahr_mul
  import wahr_pkg::*;
(
  input  logic   clk,
  input  mul_a_t a,
  input  mul_b_t b,
  output prod_t  p
);

  always_ff @(posedge clk) begin
    p <= PROD_W'(a) * PROD_W'(b);
  end

endmodule

FILE: sv/wahr_div.sv
// ----------------------------------------------------------------------------
// wahr_div
// radix-2 restoring divider giving r = 1 - theta / q, clamped at zero
// ----------------------------------------------------------------------------
module wahr_div
  import wahr_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [TH_W-1:0] th,
  input  logic [Q_W-1:0]  q,
  output logic            done,
  output logic [R_W-1:0]  r
);

  logic [Q_W-1:0]       rem;
  logic [DIV_STEPS-1:0] sh;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 busy;

  logic [Q_W:0]         rem2;
  logic [Q_W:0]         rem_sub;
  logic                 fits;
  logic [Q_W-1:0]       rem_next;
  logic [DIV_STEPS-1:0] sh_next;

  always_comb begin
    rem2     = {rem, sh[DIV_STEPS-1]};
    rem_sub  = rem2 - {1'b0, q};
    fits     = rem2 >= {1'b0, q};
    rem_next = fits ? rem_sub[Q_W-1:0] : rem2[Q_W-1:0];
    sh_next  = {sh[DIV_STEPS-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        // quotient of (th << 16) / q reaches 1.0 exactly when th >= q << 14
        if ({6'b0, th} >= {q, 14'b0}) begin
          r    <= '0;
          done <= 1'b1;
        end else begin
          rem  <= {6'b0, th[TH_W-1:14]};
          sh   <= {th[13:0], 16'b0};
          cnt  <= DIV_CNT_W'(DIV_STEPS);
          busy <= 1'b1;
        end
      end else if (busy) begin
        rem <= rem_next;
        sh  <= sh_next;
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
          r    <= ONE_Q30 - {1'b0, sh_next};
        end
      end
    end
  end

endmodule

FILE: tb/sv/wahr_out_check.sv
// ----------------------------------------------------------------------------
// wahr_out_check
// watches the wah filter channels, predicts every output sample and compares
// ----------------------------------------------------------------------------
module wahr_out_check
  import wahr_pkg::*;
#(
  parameter int SAMPLE_BITS = 24
) (
  input  logic clk,
  input  logic rst,
  wahr_in_if   din,
  wahr_out_if  dout,
  wahr_cfg_if  cfg,
  output int   pending,
  output int   mismatches,
  output int   compared
);

  typedef logic signed [SAMPLE_BITS-1:0] samp_t;

  localparam longint UNITY = longint'(ONE_Q30);
  localparam longint W_HI  = (64'sd1 <<< 39) - 1;
  localparam longint W_LO  = -(64'sd1 <<< 39);
  localparam longint S_HI  = (64'sd1 <<< (SAMPLE_BITS - 1)) - 1;
  localparam longint S_LO  = -(64'sd1 <<< (SAMPLE_BITS - 1));

  logic [FS_W-1:0] scale;
  longint          w_prev1;
  longint          w_prev2;
  longint          fb_one;
  longint          fb_two;
  longint          gain;
  samp_t           want_out[$];

  // floor(a * b / 2^30), wide enough for a 34-bit coefficient and 40-bit history
  function automatic longint q30_mul(input longint a, input longint b);
    logic signed [127:0] wa;
    logic signed [127:0] wb;
    logic signed [127:0] prod;
    wa   = a;
    wb   = b;
    prod = wa * wb;
    return longint'(prod >>> 30);
  endfunction

  function automatic longint clip(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  task automatic load_coefs(input logic [15:0] f, input logic [23:0] q);
    longint unsigned th;
    longint unsigned quot;
    longint          theta;
    longint          cosv;
    longint          sinv;
    longint          r;
    longint          g;
    th = longint'(scale);
    th = (th * f) >> 2;
    if (th > (64'd1 << 31)) th = 64'd1 << 31;
    theta = longint'(th);
    cosv  = UNITY - longint'((th * th) >> 31);
    sinv  = (theta > UNITY) ? UNITY : theta;
    if (q == '0) begin
      r = 0;
    end else begin
      quot = (th << 16) / q;
      r    = (quot >= 64'(UNITY)) ? 0 : UNITY - longint'(quot);
    end
    fb_one = -((r * cosv) >>> 29);
    fb_two = (r * r) >>> 30;
    g      = (UNITY - r) + ((r * sinv) >>> 30);
    gain   = ((UNITY - r) * g) >>> 30;
  endtask

  task automatic filter_step(input samp_t x_in, input logic [15:0] f, input logic [23:0] q,
                             input logic start, output samp_t y);
    longint x;
    longint w;
    x = x_in;
    if (start) load_coefs(f, q);
    w = x - q30_mul(fb_one, w_prev1) - q30_mul(fb_two, w_prev2);
    w = clip(w, W_LO, W_HI);
    w_prev2 = w_prev1;
    w_prev1 = w;
    y = samp_t'(clip(q30_mul(gain, w), S_LO, S_HI));
  endtask

  always @(posedge clk) begin : watch
    samp_t got;
    samp_t exp_y;
    samp_t pred;
    if (rst) begin
      scale   = FS_RESET;
      w_prev1 = 0;
      w_prev2 = 0;
      fb_one  = 0;
      fb_two  = 0;
      gain    = 0;
      want_out.delete();
      pending    <= 0;
      mismatches <= 0;
      compared   <= 0;
    end else begin
      if (cfg.valid && cfg.ready) scale = cfg.data;
      if (dout.valid && dout.ready) begin
        got = dout.sample_out;
        if (want_out.size() == 0) begin
          $error("sample_out: expected nothing, got %0d", got);
          mismatches <= mismatches + 1;
        end else begin
          exp_y = want_out.pop_front();
          compared <= compared + 1;
          if (got !== exp_y) begin
            $error("sample_out: expected %0d, got %0d", exp_y, got);
            mismatches <= mismatches + 1;
          end
        end
      end
      if (din.valid && din.ready) begin
        filter_step(din.sample_in, din.centre_freq, din.q_value, din.block_start, pred);
        want_out.push_back(pred);
      end
      pending <= want_out.size();
    end
  end

endmodule

FILE: tb/sv/tb_wah_resonator_filter.sv
// ----------------------------------------------------------------------------
// tb_wah_resonator_filter
// drives directed and random sample blocks through the wah filter under
// several frequency scales and handshake pressure; the checker judges outputs
// ----------------------------------------------------------------------------
module tb_wah_resonator_filter
  import wahr_pkg::*;
();

  localparam int SAMPLE_BITS = 24;
  localparam int CYCLE_LIMIT = 600000;
  localparam int HOLD_CYCLES = 250;

  typedef logic signed [SAMPLE_BITS-1:0] samp_t;

  localparam samp_t S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam samp_t S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  logic clk = 1'b0;
  logic rst;
  int   cycles = 0;
  int   tx_idle_pct;
  int   rx_idle_pct;
  logic rx_hold;
  int   items_sent = 0;
  int   starts_sent = 0;
  int   scale_writes = 0;
  int   hold_cycles = 0;
  int   chk_pending;
  int   chk_mismatches;
  int   chk_compared;

  wahr_in_if  #(.SAMPLE_BITS(SAMPLE_BITS)) din_ch ();
  wahr_out_if #(.SAMPLE_BITS(SAMPLE_BITS)) dout_ch ();
  wahr_cfg_if                              cfg_ch ();

  wah_resonator_filter #(.SAMPLE_BITS(SAMPLE_BITS)) dut (
    .clk  (clk),
    .rst  (rst),
    .din  (din_ch),
    .dout (dout_ch),
    .cfg  (cfg_ch)
  );

  wahr_out_check #(.SAMPLE_BITS(SAMPLE_BITS)) chk (
    .clk        (clk),
    .rst        (rst),
    .din        (din_ch),
    .dout       (dout_ch),
    .cfg        (cfg_ch),
    .pending    (chk_pending),
    .mismatches (chk_mismatches),
    .compared   (chk_compared)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("wah_resonator_filter: mismatch");
      $finish;
    end
  end

  // output side back-pressure
  initial begin
    dout_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      dout_ch.ready <= !rx_hold && (int'($urandom_range(0, 99)) >= rx_idle_pct);
    end
  end

  task automatic send_item(input samp_t s, input logic [15:0] f, input logic [23:0] q,
                           input logic bs);
    int gap;
    if (int'($urandom_range(0, 99)) < tx_idle_pct) begin
      gap = $urandom_range(1, 12);
      din_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    din_ch.valid       <= 1'b1;
    din_ch.sample_in   <= s;
    din_ch.centre_freq <= f;
    din_ch.q_value     <= q;
    din_ch.block_start <= bs;
    @(posedge clk);
    while (!din_ch.ready) @(posedge clk);
    items_sent++;
    if (bs) starts_sent++;
  endtask

  // only while the filter is drained
  task automatic write_scale(input logic [31:0] v);
    din_ch.valid <= 1'b0;
    @(posedge clk);
    while (chk_pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    scale_writes++;
  endtask

  // blocks of samples, each opened by a coefficient load, mixed with noise blocks of random starts
  task automatic run_blocks(input int n);
    int          sent;
    int          len;
    int          smode;
    logic [15:0] f;
    logic [23:0] q;
    samp_t       lvl;
    samp_t       s;
    sent = 0;
    while (sent < n) begin
      len = $urandom_range(1, 12);
      if ($urandom_range(0, 99) < 15) begin
        repeat (len) begin
          send_item(samp_t'($urandom), 16'($urandom), 24'($urandom),
                    1'($urandom_range(0, 1)));
          sent++;
        end
      end else begin
        case ($urandom_range(0, 2))
          0:       f = '0;
          1:       f = 16'($urandom_range(1, 3000));
          default: f = 16'($urandom);
        endcase
        case ($urandom_range(0, 3))
          0:       q = '0;
          1:       q = 24'($urandom_range(1, 255));
          2:       q = 24'($urandom_range(32'h8000, 32'h10_0000));
          default: q = 24'($urandom);
        endcase
        smode = $urandom_range(0, 3);
        lvl   = samp_t'($urandom_range(7000000, 8388607));
        if ($urandom_range(0, 1) == 1) lvl = -lvl;
        for (int k = 0; k < len; k++) begin
          case (smode)
            0:       s = samp_t'($urandom);
            1:       s = lvl;
            2:       s = k[0] ? S_MIN : S_MAX;
            default: s = samp_t'(int'($urandom_range(0, 511)) - 256);
          endcase
          if (k == 0) send_item(s, f, q, 1'b1);
          else        send_item(s, 16'($urandom), 24'($urandom), 1'b0);
          sent++;
        end
      end
    end
  endtask

  initial begin
    rst                <= 1'b1;
    din_ch.valid       <= 1'b0;
    din_ch.sample_in   <= '0;
    din_ch.centre_freq <= '0;
    din_ch.q_value     <= '0;
    din_ch.block_start <= 1'b0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.data        <= '0;
    rx_hold            <= 1'b0;
    rx_idle_pct        <= 68;
    tx_idle_pct         = 27;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // coefficients still zero: output stays zero while history tracks input
    send_item(S_MAX, 16'hFFFF, 24'hFF_FFFF, 1'b0);
    send_item(S_MIN, 16'h0000, 24'h00_0000, 1'b0);
    send_item(samp_t'(-1), 16'd440, 24'h01_0000, 1'b0);
    // zero q gives unity gain and no feedback
    send_item(S_MAX, 16'd1000, 24'h00_0000, 1'b1);
    send_item(S_MIN, 16'd0, 24'h00_0000, 1'b0);
    send_item(samp_t'(0), 16'd0, 24'h00_0000, 1'b0);
    // zero frequency: radius exactly one, double pole at dc
    send_item(S_MAX, 16'd0, 24'h01_0000, 1'b1);
    send_item(S_MAX, 16'd0, 24'h01_0000, 1'b0);
    // top frequency clamps theta at two
    send_item(S_MIN, 16'hFFFF, 24'hFF_FFFF, 1'b1);
    send_item(S_MAX, 16'h0, 24'h0, 1'b0);
    send_item(S_MIN, 16'h0, 24'h0, 1'b0);
    send_item(S_MAX, 16'h0, 24'h0, 1'b0);
    // tiny q drives the radius to zero
    send_item(samp_t'(12345), 16'd1000, 24'h00_0001, 1'b1);
    send_item(S_MAX, 16'd440, 24'h02_0000, 1'b1);
    send_item(S_MAX, 16'd0, 24'h0, 1'b0);
    send_item(S_MAX, 16'd0, 24'h0, 1'b0);
    send_item(S_MAX, 16'd0, 24'h0, 1'b0);
    send_item(S_MAX, 16'd0, 24'h0, 1'b0);
    send_item(S_MIN, 16'd50, 24'hFF_FFFF, 1'b1);
    send_item(S_MIN, 16'd0, 24'h0, 1'b0);
    send_item(S_MIN, 16'd0, 24'h0, 1'b0);
    send_item(S_MIN, 16'd0, 24'h0, 1'b0);
    send_item(samp_t'(0), 16'd2000, 24'h00_8000, 1'b1);

    write_scale($urandom);
    fork
      begin
        repeat (15) @(posedge clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) begin
          @(posedge clk);
          hold_cycles++;
        end
        rx_hold <= 1'b0;
      end
    join_none
    run_blocks(50);
    write_scale(32'hFFFF_FFFF);
    run_blocks(40);

    tx_idle_pct  = 68;
    rx_idle_pct <= 27;
    write_scale(32'h0);
    run_blocks(30);
    write_scale($urandom);
    run_blocks(60);

    tx_idle_pct  = 0;
    rx_idle_pct <= 0;
    write_scale(FS_RESET);
    run_blocks(70);
    // constant full scale into the dc double pole pushes the history to its rail
    send_item(S_MAX, 16'd0, 24'($urandom_range(1, 24'hFF_FFFF)), 1'b1);
    repeat (369) send_item(S_MAX, 16'($urandom), 24'($urandom), 1'b0);
    repeat (15) send_item(S_MIN, 16'($urandom), 24'($urandom), 1'b0);

    din_ch.valid <= 1'b0;
    @(posedge clk);
    while (chk_pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    $display("ran %0d sample beats with %0d block starts over %0d scale settings",
             items_sent, starts_sent, scale_writes + 1);
    $display("compared %0d outputs, output held off for %0d cycles",
             chk_compared, hold_cycles);
    if (chk_mismatches == 0) begin
      $display("wah_resonator_filter: match");
    end else begin
      $display("wah_resonator_filter: mismatch");
    end
    $finish;
  end

endmodule
